// ----- hdl/stws_pkg.sv -----
// ----------------------------------------------------------------------------
// stws_pkg
// Shared constants, types and curve-point mapping for the waveshaper.
// ----------------------------------------------------------------------------
package stws_pkg;

	localparam int MAX_COEFS = 16;
	localparam int AW        = $clog2(MAX_COEFS);
	localparam int COEF_W    = 16;
	localparam int COUNT_W   = 5;
	localparam int SEG_W     = COUNT_W + 1;
	localparam int FRAC_W    = 15;
	localparam int POS_W     = COEF_W + COUNT_W;
	localparam int SHAPED_W  = 17;

	localparam logic ACT_LOAD  = 1'b0;
	localparam logic ACT_SHAPE = 1'b1;

	// Reference to one point of the mirrored curve.
	typedef struct packed {
		logic [AW-1:0] addr;
		logic          neg;
		logic          zero;
	} point_ref_t;

	// Map curve point k of a 2n+1 point curve onto a table slot.
	function automatic point_ref_t point_map(input logic [SEG_W-1:0] k,
	                                         input logic [COUNT_W-1:0] n);
		point_ref_t          r;
		logic [SEG_W-1:0]    nn;
		logic [SEG_W-1:0]    off;
		nn     = {1'b0, n};
		r      = '0;
		if (k < nn) begin
			off    = nn - k - SEG_W'(1);
			r.addr = off[AW-1:0];
			r.neg  = 1'b1;
		end else if (k == nn) begin
			r.zero = 1'b1;
		end else begin
			off    = k - nn - SEG_W'(1);
			r.addr = off[AW-1:0];
			r.zero = (32'(off) >= MAX_COEFS);
		end
		return r;
	endfunction

endpackage

// ----- hdl/stws_ram.sv -----
// ----------------------------------------------------------------------------
// stws_ram
// Generic RAM: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module stws_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_a <= mem_q[raddr_a];
			rdata_b <= mem_q[raddr_b];
		end
	end

endmodule

// ----- hdl/symmetric_table_waveshaper.sv -----
// ----------------------------------------------------------------------------
// symmetric_table_waveshaper
// Odd-symmetric piecewise-linear waveshaper for signed Q1.15 samples.
// ----------------------------------------------------------------------------
// The block takes one request per clock while the output is not stalled. A
// request passes four register stages, the first loaded at the accepting
// edge: position multiply, coefficient RAM read, interpolation multiply, and
// the rounding add into the output register.
// Load requests (tuser low) write one
// coefficient into the table and produce no output; a sample that follows a
// load in the next cycle already sees the new value. The coefficient table
// reads as zero until a slot is written. coef_count picks how many
// coefficients form the positive half of the curve (values above the table
// size saturate, zero gives silence); write it only while the block is idle.
// Output backpressure stalls the whole pipeline.
module symmetric_table_waveshaper
	import stws_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	// configuration
	input  logic                coef_count_wr_en,
	input  logic [COUNT_W-1:0]  coef_count_wr_data,
	// request stream
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	input  logic [39:0]         s_axis_tdata,  // coef_index[3:0], coef_value[19:4],
	                                           // sample[35:20], zero pad [39:36]
	input  logic                s_axis_tuser,  // action
	input  logic                s_axis_tlast,  // last_in
	// result stream
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	output logic [23:0]         m_axis_tdata,  // shaped[16:0], zero pad [23:17]
	output logic                m_axis_tlast   // last_out
);

	// ------------------------------------------------------------------
	// Request fields
	// ------------------------------------------------------------------
	logic [3:0]          in_coef_index;
	logic [COEF_W-1:0]   in_coef_value;
	logic [15:0]         in_sample;
	logic [COEF_W-1:0]   in_u;
	logic [COUNT_W-1:0]  in_n;
	logic                advance;
	logic                accept;

	assign in_coef_index = s_axis_tdata[3:0];
	assign in_coef_value = s_axis_tdata[19:4];
	assign in_sample     = s_axis_tdata[35:20];

	// Flip the sign bit: u = s + 32768.
	assign in_u = in_sample ^ 16'h8000;

	// The whole pipeline moves unless the output register is full and held.
	logic out_valid_q;
	assign advance       = !out_valid_q || m_axis_tready;
	assign s_axis_tready = advance;
	assign accept        = s_axis_tvalid && advance;

	// ------------------------------------------------------------------
	// Configuration register
	// ------------------------------------------------------------------
	logic [COUNT_W-1:0] coef_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_count_q <= '0;
		end else if (coef_count_wr_en) begin
			coef_count_q <= coef_count_wr_data;
		end
	end

	// Saturate the count to the table size.
	assign in_n = (32'(coef_count_q) > MAX_COEFS) ? COUNT_W'(MAX_COEFS) : coef_count_q;

	// ------------------------------------------------------------------
	// Stage 1: position u*n, load payload
	// ------------------------------------------------------------------
	logic                 smp_s1;
	logic                 load_s1;
	logic [POS_W-1:0]     pos_s1;
	logic [COUNT_W-1:0]   n_s1;
	logic                 last_s1;
	logic [3:0]           idx_s1;
	logic [COEF_W-1:0]    val_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smp_s1  <= 1'b0;
			load_s1 <= 1'b0;
		end else if (advance) begin
			smp_s1  <= accept && (s_axis_tuser == ACT_SHAPE);
			load_s1 <= accept && (s_axis_tuser == ACT_LOAD);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pos_s1  <= POS_W'(in_u) * POS_W'(in_n);
			n_s1    <= in_n;
			last_s1 <= s_axis_tlast;
			idx_s1  <= in_coef_index;
			val_s1  <= in_coef_value;
		end
	end

	// Segment index and fraction; map both end points onto table slots.
	logic [SEG_W-1:0]  seg_s1;
	logic [SEG_W-1:0]  seg_next_s1;
	logic [FRAC_W-1:0] frac_s1;
	point_ref_t        pa_s1;
	point_ref_t        pb_s1;

	assign seg_s1      = pos_s1[POS_W-1:FRAC_W];
	assign seg_next_s1 = seg_s1 + SEG_W'(1);
	assign frac_s1     = pos_s1[FRAC_W-1:0];
	assign pa_s1       = point_map(seg_s1, n_s1);
	assign pb_s1       = point_map(seg_next_s1, n_s1);

	// ------------------------------------------------------------------
	// Coefficient table: write from a load leaving stage 1, read for a
	// sample leaving stage 1. Only one request sits in stage 1, so a load
	// and a later sample never touch the RAM in the same cycle.
	// ------------------------------------------------------------------
	logic                 ram_we;
	logic                 ram_re;
	logic [COEF_W-1:0]    rdata_a;
	logic [COEF_W-1:0]    rdata_b;
	logic [MAX_COEFS-1:0] written_q;

	assign ram_we = advance && load_s1 && (32'(idx_s1) < MAX_COEFS);
	assign ram_re = advance && smp_s1;

	stws_ram #(
		.WIDTH (COEF_W),
		.DEPTH (MAX_COEFS)
	) u_coef_ram (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (idx_s1[AW-1:0]),
		.wdata   (val_s1),
		.re      (ram_re),
		.raddr_a (pa_s1.addr),
		.raddr_b (pb_s1.addr),
		.rdata_a (rdata_a),
		.rdata_b (rdata_b)
	);

	// Track written slots; an unwritten slot reads as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
		end else if (ram_we) begin
			written_q[idx_s1[AW-1:0]] <= 1'b1;
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: RAM data arrives; form signed points and weights
	// ------------------------------------------------------------------
	logic              smp_s2;
	point_ref_t        pa_s2;
	point_ref_t        pb_s2;
	logic              wa_s2;
	logic              wb_s2;
	logic [FRAC_W-1:0] frac_s2;
	logic              last_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smp_s2 <= 1'b0;
		end else if (advance) begin
			smp_s2 <= smp_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ram_re) begin
			pa_s2   <= pa_s1;
			pb_s2   <= pb_s1;
			wa_s2   <= written_q[pa_s1.addr];
			wb_s2   <= written_q[pb_s1.addr];
			frac_s2 <= frac_s1;
			last_s2 <= last_s1;
		end
	end

	logic [COEF_W-1:0]          mag_a;
	logic [COEF_W-1:0]          mag_b;
	logic signed [SHAPED_W-1:0] pt_a;
	logic signed [SHAPED_W-1:0] pt_b;
	logic signed [SHAPED_W-1:0] wt_a;
	logic signed [SHAPED_W-1:0] wt_b;

	assign mag_a = (pa_s2.zero || !wa_s2) ? '0 : rdata_a;
	assign mag_b = (pb_s2.zero || !wb_s2) ? '0 : rdata_b;
	assign pt_a  = pa_s2.neg ? -$signed({1'b0, mag_a}) : $signed({1'b0, mag_a});
	assign pt_b  = pb_s2.neg ? -$signed({1'b0, mag_b}) : $signed({1'b0, mag_b});
	// Weights: 32768 - f for the left point, f for the right one.
	assign wt_a  = $signed(SHAPED_W'(32768) - SHAPED_W'(frac_s2));
	assign wt_b  = $signed(SHAPED_W'(frac_s2));

	// ------------------------------------------------------------------
	// Stage 3: registered products
	// ------------------------------------------------------------------
	localparam int PROD_W = 2 * SHAPED_W;

	logic                     smp_s3;
	logic signed [PROD_W-1:0] prod_a_s3;
	logic signed [PROD_W-1:0] prod_b_s3;
	logic                     last_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smp_s3 <= 1'b0;
		end else if (advance) begin
			smp_s3 <= smp_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && smp_s2) begin
			prod_a_s3 <= pt_a * wt_a;
			prod_b_s3 <= pt_b * wt_b;
			last_s3   <= last_s2;
		end
	end

	// Round to nearest, ties up: floor((num + 16384) / 32768).
	logic signed [PROD_W-1:0] biased;
	logic [SHAPED_W-1:0]      shaped_d;

	assign biased   = prod_a_s3 + prod_b_s3 + PROD_W'(16384);
	assign shaped_d = biased[FRAC_W+SHAPED_W-1:FRAC_W];

	// ------------------------------------------------------------------
	// Output register
	// ------------------------------------------------------------------
	logic [SHAPED_W-1:0] shaped_q;
	logic                last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= smp_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && smp_s3) begin
			shaped_q <= shaped_d;
			last_q   <= last_s3;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {7'd0, shaped_q};
	assign m_axis_tlast  = last_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
`ifndef SYNTHESIS
	// Segment index stays inside the 2n-point span of the curve.
	a_seg_range: assert property (@(posedge clk) disable iff (!arst_n)
		smp_s1 |-> (n_s1 == '0) || (seg_s1 < {n_s1, 1'b0}))
		else $error("segment index beyond curve");

	// The right end point never lies left of a positive-half left point.
	a_point_order: assert property (@(posedge clk) disable iff (!arst_n)
		(smp_s2 && !pa_s2.neg && !pa_s2.zero) |-> !pb_s2.neg)
		else $error("curve points out of order");

	// A stall freezes the product stage.
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!advance && smp_s3) |=> smp_s3 && $stable(prod_a_s3) && $stable(prod_b_s3))
		else $error("product stage moved during stall");

	// Table writes only happen while the pipeline advances.
	a_write_adv: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> advance && !smp_s1)
		else $error("table write outside an advancing load");
`endif

endmodule
